// ===== sv/tpq_pkg.sv =====
package tpq_pkg;

  // sample and calibration geometry
  localparam int SAMPLE_W  = 16;
  localparam int CAL_N     = 10;
  localparam int CNT_W     = 4;
  localparam int RANK_LO   = 2;
  localparam int AVG_N     = 6;
  localparam int SUM_W     = SAMPLE_W + 3;
  localparam int SUMCNT_W  = 3;
  localparam int GRP_SHORT = 3;
  localparam int GRP_LONG  = 6;
  localparam int SCNT_W    = 3;
  localparam int LOCK_W    = 2;
  localparam int LOCK_SET  = 3;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FSCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONT   = 2'd2;

  // command and event codes
  localparam logic CMD_CAL  = 1'b0;
  localparam logic CMD_SCAN = 1'b1;
  localparam logic EV_CAL   = 1'b0;
  localparam logic EV_SCAN  = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [SAMPLE_W-1:0] charge_time;
  } tpq_in_t;

  typedef struct packed {
    logic                event_kind;
    logic                pressed;
    logic                calib_fail;
    logic [SAMPLE_W-1:0] baseline_out;
    logic [SAMPLE_W-1:0] scan_peak_out;
  } tpq_out_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t            op;
    logic [SAMPLE_W-1:0] sample;
  } cell_ctl_t;

  // handed from one cell to its neighbor
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                take;
  } cell_link_t;

endpackage

// ===== sv/tpq_cell.sv =====
module tpq_cell (
  input  logic                          clk,
  input  tpq_pkg::cell_ctl_t            ctl,
  input  logic                          empty,
  input  tpq_pkg::cell_link_t           lnk_prev,
  input  logic [tpq_pkg::SAMPLE_W-1:0]  next_val,
  output tpq_pkg::cell_link_t           lnk_out
);
  import tpq_pkg::*;

  logic [SAMPLE_W-1:0] val_r;
  logic [SAMPLE_W-1:0] val_nxt;
  logic                take;

  // new sample belongs at or below this slot
  assign take = empty || (ctl.sample < val_r);

  always_comb begin
    case (ctl.op)
      CELL_INSERT: begin
        if (lnk_prev.take) begin
          val_nxt = lnk_prev.value;
        end else if (take) begin
          val_nxt = ctl.sample;
        end else begin
          val_nxt = val_r;
        end
      end
      CELL_SHIFT: val_nxt = next_val;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign lnk_out.value = val_r;
  assign lnk_out.take  = take;

endmodule

// ===== sv/tpq_div6.sv =====
module tpq_div6 (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tpq_pkg::SUM_W-1:0]     dividend,
  output logic                          done,
  output logic [tpq_pkg::SAMPLE_W-1:0]  quot
);
  import tpq_pkg::*;

  // floor(x / 6) equals (x * ceil(2^22 / 6)) >> 22 for every x below 2^21
  localparam int                 RECIP_SH = 22;
  localparam int                 RECIP_W  = 20;
  localparam logic [RECIP_W-1:0] RECIP_K  = 20'd699051;
  localparam int                 PROD_W   = RECIP_SH + SAMPLE_W;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [SUM_W-1:0]    div_r, div_nxt;
  logic [SAMPLE_W-1:0] q_r, q_nxt;
  logic [PROD_W-1:0]   prod;

  // sum of six samples times the reciprocal stays below 2^38
  assign prod = PROD_W'(div_r) * PROD_W'(RECIP_K);

  // latch the sum, then register the quotient taken from the multiply
  always_comb begin
    busy_nxt = 1'b0;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      div_nxt  = dividend;
    end else if (busy_r) begin
      done_nxt = 1'b1;
      q_nxt    = prod[PROD_W-1:RECIP_SH];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r <= div_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== sv/touch_pad_press_qualifier_unit.sv =====
// Touch pad press qualifier. Calibration samples (cmd 0) are collected ten
// to a round in a row of ten sorting cells: every sample is inserted in
// order, each cell either keeping its value, taking the new sample or
// taking its lower neighbor's value. After the tenth sample the row shifts
// down six times while an accumulator picks up ranks 2 to 7, and a
// reciprocal multiply divides the sum by six to give the new baseline;
// calib_fail flags a baseline above full_scale/2. Scan samples (cmd 1) are
// reduced to a peak over groups of 3, or 6 in continuous mode; a group
// reports a press when its peak exceeds baseline + gate_threshold and the
// lockout is zero, after which the lockout holds off further presses for
// the next two groups (continuous mode disregards it). A scan sample or
// one of the first nine calibration samples leaves the input ready for the
// next item whenever the output register is free; the tenth calibration
// sample keeps the input stalled through the rank sum, the divide, which
// loads the baseline, and the loading of the result into the output
// register. The result sits in an output register; a new item is taken in
// the same cycle the waiting result transfers out. Configuration is written
// through a plain write port with no read-back; index 3 is ignored.
module touch_pad_press_qualifier_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tpq_pkg::tpq_in_t                in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output tpq_pkg::tpq_out_t               out_data,
  // configuration
  input  logic                            cfg_we,
  input  logic [tpq_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tpq_pkg::SAMPLE_W-1:0]    cfg_wdata
);
  import tpq_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,   // taking samples
    ST_SUM  = 4'b0010,   // shifting ranks 2..7 into the accumulator
    ST_DIV  = 4'b0100,   // divide by six
    ST_EMIT = 4'b1000    // waiting for the output register
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [SAMPLE_W-1:0] gate_r;
  logic [SAMPLE_W-1:0] fscale_r;
  logic                cont_r;

  // block state
  logic [CNT_W-1:0]    cal_cnt_r, cal_cnt_nxt;
  logic [SAMPLE_W-1:0] baseline_r, baseline_nxt;
  logic [SAMPLE_W-1:0] scan_peak_r, scan_peak_nxt;
  logic [SCNT_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic [LOCK_W-1:0]   lock_r, lock_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [SUMCNT_W-1:0] sum_cnt_r, sum_cnt_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  tpq_out_t            out_data_r, out_data_nxt;

  logic                out_free;
  logic                in_xfer;
  logic                cal_xfer;
  logic                scan_xfer;

  // scan datapath
  logic [SAMPLE_W-1:0] peak_base;
  logic [SAMPLE_W-1:0] peak_new;
  logic [SCNT_W-1:0]   scan_inc;
  logic [SCNT_W-1:0]   grp_size;
  logic                grp_end;
  logic [SAMPLE_W:0]   level;
  logic                over;
  logic [LOCK_W-1:0]   lock_base;
  logic                press;

  // sorting row
  cell_ctl_t           cell_ctl;
  cell_link_t          lnk [CAL_N];
  logic                last_cal;

  // divider
  logic                div_start;
  logic                div_done;
  logic [SAMPLE_W-1:0] div_quot;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_xfer   = in_valid && in_ready;
  assign cal_xfer  = in_xfer && (in_data.cmd == CMD_CAL);
  assign scan_xfer = in_xfer && (in_data.cmd == CMD_SCAN);
  assign last_cal  = (cal_cnt_r == CNT_W'(CAL_N - 1));

  // ---------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_r   <= SAMPLE_W'(100);
      fscale_r <= '1;
      cont_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GATE:   gate_r   <= cfg_wdata;
        REG_FSCALE: fscale_r <= cfg_wdata;
        REG_CONT:   cont_r   <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // scan group: running peak, threshold and lockout
  // ---------------------------------------------------------------------
  assign peak_base = (scan_cnt_r == '0) ? '0 : scan_peak_r;
  assign peak_new  = (in_data.charge_time > peak_base) ? in_data.charge_time : peak_base;
  assign scan_inc  = scan_cnt_r + 1'b1;
  assign grp_size  = cont_r ? SCNT_W'(GRP_LONG) : SCNT_W'(GRP_SHORT);
  assign grp_end   = scan_inc >= grp_size;
  // compare one bit wider so baseline + gate cannot wrap
  assign level     = {1'b0, baseline_r} + {1'b0, gate_r};
  assign over      = {1'b0, peak_new} > level;
  assign lock_base = cont_r ? '0 : lock_r;
  assign press     = over && (lock_base == '0);

  // ---------------------------------------------------------------------
  // sorting row of calibration cells
  // ---------------------------------------------------------------------
  always_comb begin
    cell_ctl.sample = in_data.charge_time;
    if (cal_xfer) begin
      cell_ctl.op = CELL_INSERT;
    end else if (state_r == ST_SUM) begin
      cell_ctl.op = CELL_SHIFT;
    end else begin
      cell_ctl.op = CELL_HOLD;
    end
  end

  for (genvar i = 0; i < CAL_N; i++) begin : g_cell
    cell_link_t          prev_lnk;
    logic [SAMPLE_W-1:0] next_val;
    logic                empty;

    // slots at or beyond the fill count hold nothing of this round
    assign empty = (CNT_W'(i) >= cal_cnt_r);

    if (i == 0) begin : g_head
      assign prev_lnk = '{value: '0, take: 1'b0};
    end else begin : g_body
      assign prev_lnk = lnk[i-1];
    end

    if (i == CAL_N - 1) begin : g_tail
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = lnk[i+1].value;
    end

    tpq_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl),
      .empty    (empty),
      .lnk_prev (prev_lnk),
      .next_val (next_val),
      .lnk_out  (lnk[i])
    );
  end

  // ---------------------------------------------------------------------
  // divide the rank sum by six
  // ---------------------------------------------------------------------
  tpq_div6 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_nxt),
    .done     (div_done),
    .quot     (div_quot)
  );

  // ---------------------------------------------------------------------
  // sequencer and output register
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cal_cnt_nxt   = cal_cnt_r;
    baseline_nxt  = baseline_r;
    scan_peak_nxt = scan_peak_r;
    scan_cnt_nxt  = scan_cnt_r;
    lock_nxt      = lock_r;
    acc_nxt       = acc_r;
    sum_cnt_nxt   = sum_cnt_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (cal_xfer) begin
          if (last_cal) begin
            cal_cnt_nxt = '0;
            acc_nxt     = '0;
            sum_cnt_nxt = '0;
            state_nxt   = ST_SUM;
          end else begin
            cal_cnt_nxt = cal_cnt_r + 1'b1;
          end
        end else if (scan_xfer) begin
          scan_peak_nxt = peak_new;
          if (grp_end) begin
            scan_cnt_nxt = '0;
            if (over) begin
              lock_nxt = LOCK_W'(LOCK_SET - 1);
            end else if (lock_base != '0) begin
              lock_nxt = lock_base - 1'b1;
            end else begin
              lock_nxt = lock_base;
            end
            out_valid_nxt              = 1'b1;
            out_data_nxt.event_kind    = EV_SCAN;
            out_data_nxt.pressed       = press;
            out_data_nxt.calib_fail    = 1'b0;
            out_data_nxt.baseline_out  = baseline_r;
            out_data_nxt.scan_peak_out = peak_new;
          end else begin
            scan_cnt_nxt = scan_inc;
          end
        end
      end
      ST_SUM: begin
        // cell at rank 2 walks through ranks 2..7 as the row shifts down
        acc_nxt     = acc_r + SUM_W'(lnk[RANK_LO].value);
        sum_cnt_nxt = sum_cnt_r + 1'b1;
        if (sum_cnt_r == SUMCNT_W'(AVG_N - 1)) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          baseline_nxt = div_quot;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.event_kind    = EV_CAL;
          out_data_nxt.pressed       = 1'b0;
          out_data_nxt.calib_fail    = baseline_r > {1'b0, fscale_r[SAMPLE_W-1:1]};
          out_data_nxt.baseline_out  = baseline_r;
          out_data_nxt.scan_peak_out = '0;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cal_cnt_r   <= '0;
      baseline_r  <= '0;
      scan_peak_r <= '0;
      scan_cnt_r  <= '0;
      lock_r      <= '0;
      sum_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cal_cnt_r   <= cal_cnt_nxt;
      baseline_r  <= baseline_nxt;
      scan_peak_r <= scan_peak_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      lock_r      <= lock_nxt;
      sum_cnt_r   <= sum_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // fill count never reaches a full round; the tenth sample starts the average
  a_cal_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r < CNT_W'(CAL_N))
    else $error("calibration fill count out of range");

  // lockout is left at least one below its set value after a group
  a_lock_range: assert property (@(posedge clk) disable iff (!rst_n)
    lock_r != LOCK_W'(LOCK_SET))
    else $error("lockout holds its set value");

  // the sequencer leaves the divide state only on the divider's done
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && !div_done |=> (state_r == ST_DIV))
    else $error("left divide state early");

  // only scan results report a press
  a_press_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.pressed |-> (out_data_r.event_kind == EV_SCAN))
    else $error("press on calibration result");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tpq_pkg::*;

  // slowest correct item is a tenth calibration sample behind the longest
  // sender gap and the longest receiver stall; the limit is far above
  localparam int unsigned LIMIT_CYCLES  = 300000;
  // quiet time before a register write or the final verdict
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS  = 320;
  // index 3 has no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tpq_in_t in_data;
  logic out_valid;
  logic out_ready;
  tpq_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [SAMPLE_W-1:0] cfg_wdata;

  // shadow copy of the pad qualifier state, updated on every transfer
  logic [SAMPLE_W-1:0] cal_samples [CAL_N];
  int unsigned cal_fill = 0;
  logic [SAMPLE_W-1:0] base_level = '0;
  logic [SAMPLE_W-1:0] group_peak = '0;
  int unsigned group_fill = 0;
  int unsigned hold_off = 0;

  // shadow copy of the registers, at their reset values
  logic [SAMPLE_W-1:0] gate_q = 16'd100;
  logic [SAMPLE_W-1:0] fscale_q = 16'hFFFF;
  logic cont_q = 1'b0;

  // events still owed by the block, oldest first
  tpq_out_t events_due [$];

  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit idling_on = 1'b1;

  touch_pad_press_qualifier_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit, the only way out besides the normal end
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // clip a computed charge time into the 16-bit sample range
  function automatic logic [SAMPLE_W-1:0] clamp_sample(int value);
    if (value < 0)
      return '0;
    if (value > 65535)
      return 16'hFFFF;
    return value[SAMPLE_W-1:0];
  endfunction

  // expected behavior for one accepted sample; queues the event it causes
  function automatic void qualify_sample(tpq_in_t item);
    tpq_out_t ev;
    logic [SAMPLE_W-1:0] sorted [CAL_N];
    logic [SAMPLE_W-1:0] v;
    logic [SUM_W-1:0] rank_sum;
    int j;
    int unsigned grp_len;
    ev = '0;
    if (item.cmd == CMD_CAL) begin
      cal_samples[cal_fill] = item.charge_time;
      cal_fill++;
      if (cal_fill < CAL_N)
        return;
      cal_fill = 0;
      // sort the round, then average the middle ranks
      sorted = cal_samples;
      for (int i = 1; i < CAL_N; i++) begin
        v = sorted[i];
        j = i - 1;
        while (j >= 0 && sorted[j] > v) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = v;
      end
      rank_sum = '0;
      for (int i = RANK_LO; i < RANK_LO + AVG_N; i++)
        rank_sum += sorted[i];
      base_level = SAMPLE_W'(rank_sum / SUM_W'(AVG_N));
      ev.event_kind = EV_CAL;
      ev.calib_fail = base_level > (fscale_q >> 1);
      ev.baseline_out = base_level;
      events_due.push_back(ev);
    end else begin
      // group length follows the mode as it stands at each sample
      grp_len = cont_q ? GRP_LONG : GRP_SHORT;
      if (group_fill == 0)
        group_peak = '0;
      if (item.charge_time > group_peak)
        group_peak = item.charge_time;
      group_fill = (group_fill + 1) % 8;
      if (group_fill < grp_len)
        return;
      group_fill = 0;
      if (cont_q)
        hold_off = 0;
      // threshold compared one bit wider so baseline + gate cannot wrap
      if ({1'b0, group_peak} > {1'b0, base_level} + {1'b0, gate_q}) begin
        ev.pressed = (hold_off == 0);
        hold_off = LOCK_SET;
      end
      if (hold_off != 0)
        hold_off--;
      ev.event_kind = EV_SCAN;
      ev.baseline_out = base_level;
      ev.scan_peak_out = group_peak;
      events_due.push_back(ev);
    end
  endfunction

  function automatic void check_field(string name, logic [SAMPLE_W-1:0] want,
                                      logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      if (error_count < 10)
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // register writes land in the shadow copy at the same edge as in the block
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      case (cfg_idx)
        REG_GATE:   gate_q = cfg_wdata;
        REG_FSCALE: fscale_q = cfg_wdata;
        REG_CONT:   cont_q = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // predict on every accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      qualify_sample(in_data);
  end

  // compare every result transfer with the oldest event owed
  always @(posedge clk) begin : result_check
    tpq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        if (error_count < 10)
          $display("%0t: result transfer with nothing pending", $time);
        error_count++;
      end else begin
        want = events_due.pop_front();
        check_field("event_kind", want.event_kind, out_data.event_kind);
        check_field("pressed", want.pressed, out_data.pressed);
        check_field("calib_fail", want.calib_fail, out_data.calib_fail);
        check_field("baseline_out", want.baseline_out, out_data.baseline_out);
        check_field("scan_peak_out", want.scan_peak_out, out_data.scan_peak_out);
      end
    end
  end

  // receiver: ready drops in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one input transfer; valid is left high so back-to-back samples never
  // drop it, and only a gap or a drain lowers it
  task automatic send_sample(input logic cmd, input logic [SAMPLE_W-1:0] value);
    tpq_in_t item;
    item.cmd = cmd;
    item.charge_time = value;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // stop sending, wait for every owed event, then let a possible
  // calibration average finish before anything else happens
  task automatic drain_results();
    in_valid <= 1'b0;
    while (events_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all registers written while idle; the unused index goes last so a
  // decode slip onto a real register would show
  task automatic program_regs(input logic [SAMPLE_W-1:0] gate,
                              input logic [SAMPLE_W-1:0] fscale,
                              input logic cont, input bit hit_unused);
    drain_results();
    cfg_we <= 1'b1;
    cfg_idx <= REG_GATE;
    cfg_wdata <= gate;
    @(posedge clk);
    cfg_idx <= REG_FSCALE;
    cfg_wdata <= fscale;
    @(posedge clk);
    // upper bits of the mode write carry junk that must be ignored
    cfg_idx <= REG_CONT;
    cfg_wdata <= {15'($urandom), cont};
    @(posedge clk);
    if (hit_unused) begin
      cfg_idx <= REG_UNUSED;
      cfg_wdata <= 16'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // ten calibration samples around one level, with the odd outlier
  // that the rank trimming should throw away
  task automatic calib_round();
    int level;
    int spread;
    case ($urandom_range(0, 5))
      0: level = $urandom_range(0, 65535);
      1: level = 65535;
      2: level = 0;
      default: level = $urandom_range(200, 8000);
    endcase
    spread = $urandom_range(0, 300);
    for (int i = 0; i < CAL_N; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_sample(CMD_CAL, 16'($urandom));
      else
        send_sample(CMD_CAL, clamp_sample(level + int'($urandom_range(0, 2 * spread))
                                          - spread));
    end
  endtask

  // one scan group at the current length; a touch group carries one peak
  // above baseline + gate, the rest sit around the baseline
  task automatic scan_group();
    int unsigned grp_len;
    int unsigned peak_slot;
    bit touch;
    grp_len = cont_q ? GRP_LONG : GRP_SHORT;
    touch = $urandom_range(0, 2) != 0;
    peak_slot = $urandom_range(0, grp_len - 1);
    for (int i = 0; i < grp_len; i++) begin
      // stray calibration sample inside a scan group
      if ($urandom_range(0, 11) == 0)
        send_sample(CMD_CAL, 16'($urandom));
      if (touch && i == peak_slot)
        send_sample(CMD_SCAN, clamp_sample(int'(base_level) + int'(gate_q)
                                           + int'($urandom_range(1, 3000))));
      else if ($urandom_range(0, 9) == 0)
        send_sample(CMD_SCAN, 16'($urandom));
      else
        send_sample(CMD_SCAN, clamp_sample(int'(base_level)
                                           + int'($urandom_range(0, gate_q)) - 200));
    end
  endtask

  // first round hits both ends of the range and alternating bit patterns;
  // its middle ranks average to 32767, right at half of the default scale
  task automatic test_calibration_extremes();
    send_sample(CMD_CAL, 16'h0000);
    send_sample(CMD_CAL, 16'hFFFF);
    send_sample(CMD_CAL, 16'h5555);
    send_sample(CMD_CAL, 16'hAAAA);
    send_sample(CMD_CAL, 16'h0001);
    send_sample(CMD_CAL, 16'hFFFE);
    send_sample(CMD_CAL, 16'h0000);
    send_sample(CMD_CAL, 16'hFFFF);
    send_sample(CMD_CAL, 16'h00FF);
    send_sample(CMD_CAL, 16'hFF00);
  endtask

  // press just one count over the threshold, then a second touch held off
  // by the lockout, then a full-scale peak that a maximal gate rejects
  task automatic test_press_lockout();
    program_regs(16'd0, 16'hFFFF, 1'b0, 1'b0);
    send_sample(CMD_SCAN, 16'd32767);
    send_sample(CMD_SCAN, 16'd32768);
    send_sample(CMD_SCAN, 16'd100);
    send_sample(CMD_SCAN, 16'd32768);
    send_sample(CMD_SCAN, 16'd0);
    send_sample(CMD_SCAN, 16'd0);
    program_regs(16'hFFFF, 16'd0, 1'b0, 1'b0);
    repeat (3) send_sample(CMD_SCAN, 16'hFFFF);
  endtask

  // short group left half done, then continuous mode stretches it to six;
  // a calibration sample in the middle must not disturb it, and the write
  // to the unused index must not touch the gate
  task automatic test_mode_switch();
    program_regs(16'd0, 16'd0, 1'b0, 1'b0);
    send_sample(CMD_SCAN, 16'd40000);
    send_sample(CMD_SCAN, 16'd1);
    program_regs(16'd0, 16'd0, 1'b1, 1'b1);
    send_sample(CMD_SCAN, 16'd0);
    send_sample(CMD_CAL, 16'd12345);
    repeat (3) send_sample(CMD_SCAN, 16'd0);
  endtask

  // phases of random settings, each a possible calibration round and a few
  // scan groups; every fourth phase runs with no idling at all
  task automatic test_random_traffic(input int unsigned budget);
    int unsigned stop_at;
    int unsigned phase;
    logic [SAMPLE_W-1:0] gate_v;
    logic [SAMPLE_W-1:0] fscale_v;
    stop_at = sent_count + budget;
    phase = 0;
    while (sent_count < stop_at) begin
      case ($urandom_range(0, 5))
        0: gate_v = 16'd0;
        1: gate_v = 16'hFFFF;
        2: gate_v = 16'($urandom);
        default: gate_v = 16'($urandom_range(0, 600));
      endcase
      case ($urandom_range(0, 4))
        0: fscale_v = 16'd0;
        1: fscale_v = 16'hFFFF;
        2: fscale_v = 16'd1;
        default: fscale_v = 16'($urandom);
      endcase
      program_regs(gate_v, fscale_v, 1'($urandom), $urandom_range(0, 3) == 0);
      idling_on = (phase % 4) != 3;
      if (phase == 0 || $urandom_range(0, 2) == 0)
        calib_round();
      repeat ($urandom_range(2, 6)) scan_group();
      phase++;
    end
  endtask

  // closing stretch with both sides always ready
  task automatic test_steady_stream();
    drain_results();
    idling_on = 1'b0;
    calib_round();
    repeat (8) scan_group();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_GATE;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calibration_extremes();
    test_press_lockout();
    test_mode_switch();
    test_random_traffic(RANDOM_ITEMS);
    test_steady_stream();

    drain_results();
    if (error_count == 0 && events_due.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
sv/tpq_pkg.sv
sv/tpq_cell.sv
sv/tpq_div6.sv
sv/touch_pad_press_qualifier_unit.sv
test/tb_top.sv
